/* src/osmm_pkg.sv */
// shared types and constants of the owned segment memory manager
package osmm_pkg;

  localparam int unsigned MEM_WORDS_DEF = 1024;
  localparam int unsigned PID_BITS_DEF  = 8;
  localparam int unsigned PID_MAX_BITS  = 16;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned SIZE_W = 11;
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned PIDI_W = 8;

  localparam int unsigned IN_W   = OP_W + SIZE_W + ADDR_W + DATA_W + PIDI_W;
  localparam int unsigned IN_TW  = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_W  = 1 + ADDR_W + DATA_W;
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_MALLOC = 3'd0,
    OP_FREE   = 3'd1,
    OP_PUSH   = 3'd2,
    OP_POP    = 3'd3,
    OP_LOAD   = 3'd4,
    OP_STORE  = 3'd5,
    OP_CTX    = 3'd6
  } op_e;

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_EXEC  = 8'b0000_0100,
    S_FILL  = 8'b0000_1000,
    S_SWEEP = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_POP   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic init;
    logic latch;
    logic exec;
    logic fill;
    logic sweep;
    logic scan;
    logic pop;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic go_fill;
    logic go_sweep;
    logic go_scan;
    logic fill_last;
    logic sweep_last;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

/* src/osmm_ctrl.sv */
// sequencing state machine of the owned segment memory manager
module osmm_ctrl import osmm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.init = 1'b1;
        if (sts_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.go_fill) begin
          state_d = S_FILL;
        end else if (sts_i.go_sweep) begin
          state_d = S_SWEEP;
        end else if (sts_i.go_scan) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_DONE;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = S_POP;
        end else if (sts_i.scan_end) begin
          state_d = S_DONE;
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        cmd_o.done = 1'b1;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

endmodule

/* src/osmm_datapath.sv */
// tag and data memories, pointers and result registers
module osmm_datapath import osmm_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  parameter int unsigned PID_BITS  = PID_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [OP_W-1:0]   in_op_i,
  input  logic [SIZE_W-1:0] in_size_i,
  input  logic [ADDR_W-1:0] in_addr_i,
  input  logic [DATA_W-1:0] in_din_i,
  input  logic [PIDI_W-1:0] in_pid_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_status_o,
  output logic [ADDR_W-1:0] out_raddr_o,
  output logic [DATA_W-1:0] out_dout_o
);

  localparam int unsigned AW    = $clog2(MEM_WORDS);
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned PTR_W = ((AW + 1 > SIZE_W) ? AW + 1 : SIZE_W) + 1;
  localparam int unsigned TAG_W = PID_BITS + 1;
  localparam logic [TAG_W-1:0] NO_OWNER = {1'b1, {PID_BITS{1'b0}}};

  logic [TAG_W-1:0]  tag_mem [MEM_WORDS];
  logic [DATA_W-1:0] data_mem [MEM_WORDS];

  op_e               op_q;
  logic [SIZE_W-1:0] size_q;
  logic [PTR_W-1:0]  addr_q;
  logic [DATA_W-1:0] din_q;
  logic [PIDI_W-1:0] pid_q;

  logic [PTR_W-1:0]  heap_q, stack_q;
  logic [TAG_W-1:0]  act_q;
  logic [CW-1:0]     cnt_q;
  logic              rd_vld_q;
  logic [AW-1:0]     rd_addr_q;
  logic [TAG_W-1:0]  tag_rd_q;
  logic [DATA_W-1:0] data_rd_q;

  logic              res_status_q;
  logic [ADDR_W-1:0] res_raddr_q;
  logic [DATA_W-1:0] res_dout_q;

  logic              out_valid_q;
  logic              out_status_q;
  logic [ADDR_W-1:0] out_raddr_q;
  logic [DATA_W-1:0] out_dout_q;

  logic [PTR_W-1:0]        in_addr_ext;
  logic [PTR_W-1:0]        heap_plus_size;
  logic [PID_MAX_BITS-1:0] pid_wide;
  logic                    malloc_ok, push_ok, pop_ok, acc_ok, tag_match, cnt_end;

  logic              tag_we;
  logic [AW-1:0]     tag_wa, tag_ra;
  logic [TAG_W-1:0]  tag_wd;
  logic              data_we;
  logic [AW-1:0]     data_wa, data_ra;

  assign in_addr_ext    = {{(PTR_W-ADDR_W){1'b0}}, in_addr_i};
  assign heap_plus_size = heap_q + {{(PTR_W-SIZE_W){1'b0}}, size_q};
  assign pid_wide       = {{(PID_MAX_BITS-PIDI_W){1'b0}}, pid_q};

  assign malloc_ok = (act_q != NO_OWNER) && (heap_plus_size < stack_q);
  assign push_ok   = ((heap_q + PTR_W'(1)) != stack_q) && (stack_q != '0);
  assign pop_ok    = (stack_q + PTR_W'(1)) != PTR_W'(MEM_WORDS);
  assign acc_ok    = (addr_q < heap_q) && (tag_rd_q == act_q);
  assign tag_match = rd_vld_q && (tag_rd_q == act_q);
  assign cnt_end   = cnt_q == CW'(MEM_WORDS);

  always_comb begin
    sts_o            = '0;
    sts_o.init_last  = cnt_q == CW'(MEM_WORDS - 1);
    sts_o.go_fill    = (op_q == OP_MALLOC) && malloc_ok && (size_q != '0);
    sts_o.go_sweep   = op_q == OP_FREE;
    sts_o.go_scan    = (op_q == OP_POP) && pop_ok;
    sts_o.fill_last  = {{(PTR_W-CW){1'b0}}, cnt_q} == (heap_plus_size - PTR_W'(1));
    sts_o.sweep_last = cnt_end;
    sts_o.scan_hit   = tag_match;
    sts_o.scan_end   = cnt_end && !tag_match;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    tag_we  = 1'b0;
    tag_wa  = cnt_q[AW-1:0];
    tag_wd  = NO_OWNER;
    data_we = 1'b0;
    data_wa = stack_q[AW-1:0];
    if (cmd_i.init) begin
      tag_we = 1'b1;
    end else if (cmd_i.fill) begin
      tag_we = 1'b1;
      tag_wd = act_q;
    end else if ((cmd_i.sweep || cmd_i.scan) && tag_match) begin
      tag_we = 1'b1;
      tag_wa = rd_addr_q;
    end else if (cmd_i.exec && (op_q == OP_PUSH) && push_ok) begin
      tag_we  = 1'b1;
      tag_wa  = stack_q[AW-1:0];
      tag_wd  = act_q;
      data_we = 1'b1;
    end else if (cmd_i.exec && (op_q == OP_STORE) && acc_ok) begin
      data_we = 1'b1;
      data_wa = addr_q[AW-1:0];
    end
  end

  assign tag_ra  = (cmd_i.sweep || cmd_i.scan) ? cnt_q[AW-1:0] : in_addr_ext[AW-1:0];
  assign data_ra = cmd_i.scan ? rd_addr_q : in_addr_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    tag_rd_q <= tag_mem[tag_ra];
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_wa] <= din_q;
    end
    data_rd_q <= data_mem[data_ra];
  end

  // item fields and scan address
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= op_e'(in_op_i);
      size_q <= in_size_i;
      addr_q <= in_addr_ext;
      din_q  <= in_din_i;
      pid_q  <= in_pid_i;
    end
    rd_addr_q <= cnt_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q   <= PTR_W'(1);
      stack_q  <= PTR_W'(MEM_WORDS - 1);
      act_q    <= NO_OWNER;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.init || cmd_i.fill) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.sweep || cmd_i.scan) begin
        rd_vld_q <= !cnt_end;
        if (!cnt_end) begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.fill && sts_o.fill_last) begin
        heap_q <= heap_plus_size;
      end
      if (cmd_i.exec) begin
        rd_vld_q <= 1'b0;
        case (op_q)
          OP_MALLOC, OP_POP: cnt_q <= heap_q[CW-1:0];
          OP_FREE:           cnt_q <= '0;
          OP_PUSH: begin
            if (push_ok) begin
              stack_q <= stack_q - PTR_W'(1);
            end
          end
          OP_CTX:  act_q <= {1'b0, pid_wide[PID_BITS-1:0]};
          default: ;
        endcase
      end
    end
  end

  // pending result
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_status_q <= 1'b1;
      res_raddr_q  <= '0;
      res_dout_q   <= '0;
      case (op_q)
        OP_MALLOC: begin
          if (malloc_ok) begin
            res_status_q <= 1'b0;
            res_raddr_q  <= heap_q[ADDR_W-1:0];
          end
        end
        OP_FREE, OP_CTX: res_status_q <= 1'b0;
        OP_PUSH: begin
          if (push_ok) begin
            res_status_q <= 1'b0;
            res_raddr_q  <= stack_q[ADDR_W-1:0];
          end
        end
        OP_LOAD: begin
          if (acc_ok) begin
            res_status_q <= 1'b0;
            res_dout_q   <= data_rd_q;
          end
        end
        OP_STORE: begin
          if (acc_ok) begin
            res_status_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.pop) begin
      res_status_q <= 1'b0;
      res_dout_q   <= data_rd_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.done && sts_o.out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done && sts_o.out_free) begin
      out_status_q <= res_status_q;
      out_raddr_q  <= res_raddr_q;
      out_dout_q   <= res_dout_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_raddr_o  = out_raddr_q;
  assign out_dout_o   = out_dout_q;

endmodule

/* src/owned_segment_memory_manager_top.sv */
// top level of the owned segment memory manager
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       op, alloc_size, address, data_in, process_id
//   m_axis    out  m_axis_tvalid/tready       status, result_address, data_out
//
// after reset a clearing pass marks every tag word unowned with s_axis_tready low
// context switch, load, store, push, failed malloc and pop on an empty stack: exec, done
// malloc on success fills alloc_size tags; free sweeps every tag, one address per cycle
// pop scans tags from heap_top up, one per cycle, and on a hit returns that word's data
// a waiting result sits in the output register while the next item is taken
module owned_segment_memory_manager_top import osmm_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF,
  parameter int unsigned PID_BITS  = PID_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_TW-1:0]  s_axis_tdata,  // op, alloc_size, address, data_in, process_id
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_TW-1:0] m_axis_tdata   // status, result_address, data_out
);

  localparam int unsigned SIZE_LO = OP_W;
  localparam int unsigned ADDR_LO = SIZE_LO + SIZE_W;
  localparam int unsigned DIN_LO  = ADDR_LO + ADDR_W;
  localparam int unsigned PID_LO  = DIN_LO + DATA_W;

  cmd_t              cmd;
  sts_t              sts;
  logic              out_status;
  logic [ADDR_W-1:0] out_raddr;
  logic [DATA_W-1:0] out_dout;

  osmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  osmm_datapath #(
    .MEM_WORDS (MEM_WORDS),
    .PID_BITS  (PID_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (s_axis_tdata[OP_W-1:0]),
    .in_size_i    (s_axis_tdata[SIZE_LO +: SIZE_W]),
    .in_addr_i    (s_axis_tdata[ADDR_LO +: ADDR_W]),
    .in_din_i     (s_axis_tdata[DIN_LO +: DATA_W]),
    .in_pid_i     (s_axis_tdata[PID_LO +: PIDI_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_raddr_o  (out_raddr),
    .out_dout_o   (out_dout)
  );

  assign m_axis_tdata = {{(OUT_TW-OUT_W){1'b0}}, out_dout, out_raddr, out_status};

endmodule
